FILE: rtl/core/drt_pkg.sv
// ----------------------------------------------------------------------------
// drt_pkg
// Shared types and constants of the divider and reload timer.
// ----------------------------------------------------------------------------
package drt_pkg;

    localparam int CYCLE_WIDTH_DEF = 32;
    localparam int ADDR_W          = 5;
    localparam int DATA_W          = 32;
    localparam int Q_DEPTH         = 2;
    localparam int Q_PTR_W         = $clog2(Q_DEPTH);
    localparam int Q_CNT_W         = $clog2(Q_DEPTH + 1);

    localparam logic [2:0] CTL_ENABLE = 3'h4;
    localparam logic [2:0] CTL_SELECT = 3'h3;
    localparam logic [7:0] COUNT_TOP  = 8'hFF;

    // input kind codes
    localparam logic [1:0] KIND_SYNC    = 2'd0;
    localparam logic [1:0] KIND_DIV_RST = 2'd1;
    localparam logic [1:0] KIND_WR_CTL  = 2'd2;

    typedef enum logic [2:0] {
        REG_DIV_PERIOD = 3'd0,
        REG_PERIOD_SEL0 = 3'd1,
        REG_PERIOD_SEL1 = 3'd2,
        REG_PERIOD_SEL2 = 3'd3,
        REG_PERIOD_SEL3 = 3'd4,
        REG_RELOAD      = 3'd5,
        REG_IRQ_EN      = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        OP_SYNC,
        OP_DIV_RST,
        OP_WR_CTL,
        OP_NONE
    } t_op;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] cycle_now;
        logic [2:0]  control_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] div_value;
        logic [7:0] count_value;
        logic       irq_raised;
    } t_out_item;

    typedef struct packed {
        t_op         op;
        logic [31:0] cycle_now;
        logic [2:0]  ctl;
    } t_cmd;

    typedef struct packed {
        logic [15:0]       div_period;
        logic [3:0][15:0]  period_sel;
        logic [7:0]        reload_value;
        logic              irq_enable;
    } t_cfg;

endpackage

FILE: rtl/core/drt_regs.sv
// ----------------------------------------------------------------------------
// drt_regs
// APB-style configuration registers, one per word address.
// ----------------------------------------------------------------------------
module drt_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [drt_pkg::ADDR_W-1:0]  paddr,
    input  logic [drt_pkg::DATA_W-1:0]  pwdata,
    output logic [drt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output drt_pkg::t_cfg               o_cfg
);
    import drt_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx idx;
    logic     wr_en;

    assign idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.div_period    <= 16'd256;
            r_cfg.period_sel[0] <= 16'd1024;
            r_cfg.period_sel[1] <= 16'd16;
            r_cfg.period_sel[2] <= 16'd64;
            r_cfg.period_sel[3] <= 16'd256;
            r_cfg.reload_value  <= 8'd0;
            r_cfg.irq_enable    <= 1'b0;
        end else if (wr_en) begin
            unique case (idx)
                REG_DIV_PERIOD:  r_cfg.div_period    <= pwdata[15:0];
                REG_PERIOD_SEL0: r_cfg.period_sel[0] <= pwdata[15:0];
                REG_PERIOD_SEL1: r_cfg.period_sel[1] <= pwdata[15:0];
                REG_PERIOD_SEL2: r_cfg.period_sel[2] <= pwdata[15:0];
                REG_PERIOD_SEL3: r_cfg.period_sel[3] <= pwdata[15:0];
                REG_RELOAD:      r_cfg.reload_value  <= pwdata[7:0];
                REG_IRQ_EN:      r_cfg.irq_enable    <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_DIV_PERIOD:  prdata = DATA_W'(r_cfg.div_period);
            REG_PERIOD_SEL0: prdata = DATA_W'(r_cfg.period_sel[0]);
            REG_PERIOD_SEL1: prdata = DATA_W'(r_cfg.period_sel[1]);
            REG_PERIOD_SEL2: prdata = DATA_W'(r_cfg.period_sel[2]);
            REG_PERIOD_SEL3: prdata = DATA_W'(r_cfg.period_sel[3]);
            REG_RELOAD:      prdata = DATA_W'(r_cfg.reload_value);
            REG_IRQ_EN:      prdata = DATA_W'(r_cfg.irq_enable);
            default:         prdata = '0;
        endcase
    end

endmodule

FILE: rtl/core/drt_front.sv
// ----------------------------------------------------------------------------
// drt_front
// Accepts input words, decodes the kind and queues commands for the back end.
// ----------------------------------------------------------------------------
module drt_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  drt_pkg::t_in_item i_in,
    output logic              o_cmd_valid,
    output drt_pkg::t_cmd     o_cmd,
    input  logic              i_cmd_take
);
    import drt_pkg::*;

    t_cmd               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_cnt;
    t_cmd               cmd;
    logic               do_push, do_pop;

    always_comb begin
        cmd.cycle_now = i_in.cycle_now;
        cmd.ctl       = i_in.control_value;
        unique case (i_in.kind)
            KIND_SYNC:    cmd.op = OP_SYNC;
            KIND_DIV_RST: cmd.op = OP_DIV_RST;
            KIND_WR_CTL:  cmd.op = OP_WR_CTL;
            default:      cmd.op = OP_NONE;
        endcase
    end

    assign full        = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign do_push     = push && !full;
    assign o_cmd_valid = (r_cnt != '0);
    assign do_pop      = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_cnt <= r_cnt + Q_CNT_W'(do_push) - Q_CNT_W'(do_pop);
        end
    end

endmodule

FILE: rtl/core/drt_back.sv
// ----------------------------------------------------------------------------
// drt_back
// Executes one command per cycle, while the result queue has room, on the
// divider and counter state and queues the result word.
// ----------------------------------------------------------------------------
module drt_back #(
    parameter int CYCLE_WIDTH = drt_pkg::CYCLE_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  drt_pkg::t_cfg      i_cfg,
    input  logic               i_cmd_valid,
    input  drt_pkg::t_cmd      i_cmd,
    output logic               o_cmd_take,
    output logic               empty,
    input  logic               pop,
    output drt_pkg::t_out_item o_out
);
    import drt_pkg::*;

    logic [7:0]             r_div, n_div;
    logic [7:0]             r_cnt, n_cnt;
    logic [2:0]             r_ctl, n_ctl;
    logic [CYCLE_WIDTH-1:0] r_div_base, n_div_base;
    logic [CYCLE_WIDTH-1:0] r_cnt_base, n_cnt_base;

    logic [CYCLE_WIDTH-1:0] now, div_el, cnt_el, div_per, cnt_per;
    logic [2:0]             ctl;
    logic                   do_cnt, irq;

    t_out_item          r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [Q_CNT_W-1:0] r_qcnt;
    logic               fire, do_pop;

    always_comb begin
        n_div      = r_div;
        n_cnt      = r_cnt;
        n_ctl      = r_ctl;
        n_div_base = r_div_base;
        n_cnt_base = r_cnt_base;
        irq        = 1'b0;
        do_cnt     = 1'b0;

        now     = CYCLE_WIDTH'(i_cmd.cycle_now);
        div_per = CYCLE_WIDTH'(i_cfg.div_period);
        div_el  = now - r_div_base;
        ctl     = (i_cmd.op == OP_WR_CTL) ? i_cmd.ctl : r_ctl;
        cnt_per = CYCLE_WIDTH'(i_cfg.period_sel[2'(ctl & CTL_SELECT)]);
        cnt_el  = now - r_cnt_base;

        unique case (i_cmd.op)
            OP_SYNC: begin
                if (div_el >= div_per) begin
                    n_div      = r_div + 8'd1;
                    n_div_base = r_div_base + div_per;
                end
                do_cnt = 1'b1;
            end
            OP_DIV_RST: begin
                n_div      = '0;
                n_div_base = now;
            end
            OP_WR_CTL: begin
                n_ctl  = ctl;
                do_cnt = 1'b1;
            end
            OP_NONE: ;
            default: ;
        endcase

        if (do_cnt) begin
            if ((ctl & CTL_ENABLE) != '0) begin
                if (cnt_el >= cnt_per) begin
                    if (r_cnt == COUNT_TOP) begin
                        n_cnt = i_cfg.reload_value;
                        irq   = i_cfg.irq_enable;
                    end else begin
                        n_cnt = r_cnt + 8'd1;
                    end
                    n_cnt_base = r_cnt_base + cnt_per;
                end
            end else begin
                // disabled: period base tracks the cycle count
                n_cnt_base = now;
            end
        end
    end

    assign o_cmd_take = (r_qcnt != Q_CNT_W'(Q_DEPTH));
    assign fire       = i_cmd_valid && o_cmd_take;
    assign empty      = (r_qcnt == '0);
    assign do_pop     = pop && !empty;
    assign o_out      = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_mem[r_wptr] <= '{div_value: n_div, count_value: n_cnt, irq_raised: irq};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div      <= '0;
            r_cnt      <= '0;
            r_ctl      <= '0;
            r_div_base <= '0;
            r_cnt_base <= '0;
            r_wptr     <= '0;
            r_rptr     <= '0;
            r_qcnt     <= '0;
        end else begin
            if (fire) begin
                r_div      <= n_div;
                r_cnt      <= n_cnt;
                r_ctl      <= n_ctl;
                r_div_base <= n_div_base;
                r_cnt_base <= n_cnt_base;
                r_wptr     <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_qcnt <= r_qcnt + Q_CNT_W'(fire) - Q_CNT_W'(do_pop);
        end
    end

endmodule

FILE: rtl/core/divider_and_reload_timer.sv
// ----------------------------------------------------------------------------
// divider_and_reload_timer
// Free-running divider and reloadable counter stepped by machine cycle count.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per clock when
// pop keeps up. A pushed word waits in the input queue, is executed when
// the result queue has room, and its result is written to the result queue.
// The rate is set by the execute stage (elapsed-cycle subtract and compare on
// each unit); two-entry queues sit on the input side and the result side so
// each end may stall independently. Registers sit at byte addresses 4*i and
// must only be written while the timer is idle.
module divider_and_reload_timer #(
    parameter int CYCLE_WIDTH = drt_pkg::CYCLE_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  drt_pkg::t_in_item           i_in,
    output logic                        empty,
    input  logic                        pop,
    output drt_pkg::t_out_item          o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [drt_pkg::ADDR_W-1:0]  paddr,
    input  logic [drt_pkg::DATA_W-1:0]  pwdata,
    output logic [drt_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import drt_pkg::*;

    t_cfg cfg;
    t_cmd cmd;
    logic cmd_valid, cmd_take;

    drt_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    drt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_in        (i_in),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    drt_back #(
        .CYCLE_WIDTH (CYCLE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .empty       (empty),
        .pop         (pop),
        .o_out       (o_out)
    );

endmodule

FILE: rtl/core/drt_checker.sv
// ----------------------------------------------------------------------------
// drt_checker
// Port-level checks of the timer, bound to the top level.
// ----------------------------------------------------------------------------
module drt_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        push,
    input logic                        full,
    input logic                        empty,
    input logic                        pop,
    input drt_pkg::t_out_item          o_out,
    input logic                        psel,
    input logic                        penable,
    input logic                        pwrite,
    input logic [drt_pkg::ADDR_W-1:0]  paddr,
    input logic [drt_pkg::DATA_W-1:0]  pwdata,
    input logic                        pready
);
    import drt_pkg::*;

    logic [3:0] r_pending;
    logic [7:0] r_reload;
    logic       r_irq_en;
    logic       wr_en;
    t_reg_idx   idx;

    assign wr_en = psel && penable && pwrite && pready;
    assign idx   = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_reload  <= '0;
            r_irq_en  <= 1'b0;
        end else begin
            r_pending <= r_pending + 4'(push && !full) - 4'(pop && !empty);
            if (wr_en && idx == REG_RELOAD) begin
                r_reload <= pwdata[7:0];
            end
            if (wr_en && idx == REG_IRQ_EN) begin
                r_irq_en <= pwdata[0];
            end
        end
    end

    // a waiting result holds until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_out)))
        else $error("result changed while stalled");

    // no result without an accepted word
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (r_pending != '0))
        else $error("result without a pending word");

    // interrupt only when enabled
    a_irq_en: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.irq_raised) |-> r_irq_en)
        else $error("interrupt raised while disabled");

    // an overflow leaves the counter at the reload value
    a_irq_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_out.irq_raised) |-> (o_out.count_value == r_reload))
        else $error("overflow did not reload counter");

endmodule

bind divider_and_reload_timer drt_checker u_drt_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_out   (o_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .pready  (pready)
);
